/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define LPF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define LPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lpf_pkg.sv */
// shared constants, types and state encodings of the palindrome finder
package lpf_pkg;

    // string capacity and derived widths
    localparam int MAX_LEN = 1024;
    localparam int AW      = $clog2(MAX_LEN);
    localparam int CW      = $clog2(MAX_LEN + 1);
    localparam int BYTE_W  = 8;

    // text store write request from the load side
    typedef struct packed {
        logic              en;
        logic [AW-1:0]     addr;
        logic [BYTE_W-1:0] data;
    } lpf_wr_t;

    // search start request
    typedef struct packed {
        logic          start;
        logic [CW-1:0] n;
    } lpf_cmd_t;

    // search result, start and length hold until the next start
    typedef struct packed {
        logic          done;
        logic [AW-1:0] start;
        logic [CW-1:0] length;
    } lpf_res_t;

    // top level control states
    typedef enum logic [1:0] {
        T_LOAD,
        T_SEARCH,
        T_HOLD
    } lpf_top_state_t;

    // search sequencer states
    typedef enum logic [2:0] {
        E_IDLE,
        E_CENTER,
        E_MIRROR,
        E_PROBE,
        E_CMP,
        E_FINISH
    } lpf_eng_state_t;

endpackage

/* design/lpf_engine.sv */
// manacher search sequencer with text and radius stores
module lpf_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  lpf_pkg::lpf_wr_t txt_wr,
    input  lpf_pkg::lpf_cmd_t cmd,
    output lpf_pkg::lpf_res_t res
);

    // stores
    logic [lpf_pkg::BYTE_W-1:0] text_mem [lpf_pkg::MAX_LEN];
    logic [lpf_pkg::AW-1:0]     rad_mem  [lpf_pkg::MAX_LEN];

    logic [lpf_pkg::BYTE_W-1:0] txt_a_q;
    logic [lpf_pkg::BYTE_W-1:0] txt_b_q;
    logic [lpf_pkg::AW-1:0]     rad_q;
    logic [lpf_pkg::AW-1:0]     txt_a_addr;
    logic [lpf_pkg::AW-1:0]     txt_b_addr;
    logic [lpf_pkg::AW-1:0]     rad_addr;
    logic                       rad_we;

    // sequencer registers
    lpf_pkg::lpf_eng_state_t state_reg, state_next;
    logic                    pass_reg, pass_next;
    logic                    done_reg, done_next;
    logic [lpf_pkg::AW-1:0]  i_reg, i_next;
    logic [lpf_pkg::CW-1:0]  n_reg, n_next;
    logic [lpf_pkg::CW-1:0]  k_reg, k_next;
    logic [lpf_pkg::AW-1:0]  wl_reg, wl_next;
    logic [lpf_pkg::CW-1:0]  wr1_reg, wr1_next;
    logic [lpf_pkg::CW-1:0]  best_len_reg, best_len_next;
    logic [lpf_pkg::AW-1:0]  best_start_reg, best_start_next;

    // widened operands for the add and compare logic
    logic [lpf_pkg::CW:0] i_w;
    logic [lpf_pkg::CW:0] k_w;
    logic [lpf_pkg::CW:0] n_w;
    logic [lpf_pkg::CW:0] wl_w;
    logic [lpf_pkg::CW:0] wr1_w;
    logic [lpf_pkg::CW:0] pass_w;
    logic [lpf_pkg::CW:0] odd_w;
    logic [lpf_pkg::CW:0] rad_w;
    logic [lpf_pkg::CW:0] span_w;
    logic [lpf_pkg::CW:0] reach_w;
    logic [lpf_pkg::CW:0] cand_len;
    logic [lpf_pkg::CW:0] cand_start;
    logic                 in_window;
    logic                 probe_ok;
    logic                 chars_match;
    logic                 last_center;

    assign i_w     = (lpf_pkg::CW + 1)'(i_reg);
    assign k_w     = (lpf_pkg::CW + 1)'(k_reg);
    assign n_w     = (lpf_pkg::CW + 1)'(n_reg);
    assign wl_w    = (lpf_pkg::CW + 1)'(wl_reg);
    assign wr1_w   = (lpf_pkg::CW + 1)'(wr1_reg);
    assign pass_w  = (lpf_pkg::CW + 1)'(pass_reg);
    assign odd_w   = (lpf_pkg::CW + 1)'(!pass_reg);
    assign rad_w   = (lpf_pkg::CW + 1)'(rad_q);

    // window end is kept one past its last index, so empty is zero
    assign in_window   = i_w < wr1_w;
    assign span_w      = wr1_w - i_w;
    assign reach_w     = i_w + k_w;
    assign probe_ok    = (i_w >= k_w + pass_w) && (reach_w < n_w);
    assign chars_match = txt_a_q == txt_b_q;
    assign last_center = (i_w + 1'b1) == n_w;
    assign cand_len    = (k_w << 1) - odd_w;
    assign cand_start  = i_w - k_w + odd_w;

    // store addresses
    assign txt_a_addr = lpf_pkg::AW'(i_w - k_w - pass_w);
    assign txt_b_addr = lpf_pkg::AW'(reach_w);
    assign rad_addr   = lpf_pkg::AW'(wl_w + wr1_w - i_w - odd_w);

    // text store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (txt_wr.en)
        begin
            text_mem[txt_wr.addr] <= txt_wr.data;
        end
        txt_a_q <= text_mem[txt_a_addr];
        txt_b_q <= text_mem[txt_b_addr];
    end

    // radius store shared by both passes
    always_ff @(posedge clk)
    begin
        if (rad_we)
        begin
            rad_mem[i_reg] <= k_reg[lpf_pkg::AW-1:0];
        end
        rad_q <= rad_mem[rad_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpf_pkg::E_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = lpf_pkg::E_CENTER;
                end
            end
            lpf_pkg::E_CENTER:
            begin
                state_next = in_window ? lpf_pkg::E_MIRROR : lpf_pkg::E_PROBE;
            end
            lpf_pkg::E_MIRROR:
            begin
                state_next = lpf_pkg::E_PROBE;
            end
            lpf_pkg::E_PROBE:
            begin
                state_next = probe_ok ? lpf_pkg::E_CMP : lpf_pkg::E_FINISH;
            end
            lpf_pkg::E_CMP:
            begin
                state_next = chars_match ? lpf_pkg::E_PROBE : lpf_pkg::E_FINISH;
            end
            lpf_pkg::E_FINISH:
            begin
                if (last_center && pass_reg)
                begin
                    state_next = lpf_pkg::E_IDLE;
                end
                else
                begin
                    state_next = lpf_pkg::E_CENTER;
                end
            end
            default:
            begin
                state_next = lpf_pkg::E_IDLE;
            end
        endcase
    end

    // datapath updates per state
    always_comb
    begin
        pass_next       = pass_reg;
        done_next       = 1'b0;
        i_next          = i_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        wl_next         = wl_reg;
        wr1_next        = wr1_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        rad_we          = 1'b0;
        case (state_reg)
            lpf_pkg::E_IDLE:
            begin
                if (cmd.start)
                begin
                    n_next          = cmd.n;
                    pass_next       = 1'b0;
                    i_next          = '0;
                    wl_next         = '0;
                    wr1_next        = '0;
                    best_len_next   = '0;
                    best_start_next = '0;
                end
            end
            lpf_pkg::E_CENTER:
            begin
                // outside the window: odd radius counts the center itself
                if (!in_window)
                begin
                    k_next = lpf_pkg::CW'(odd_w);
                end
            end
            lpf_pkg::E_MIRROR:
            begin
                // mirror radius clipped to the window edge
                k_next = lpf_pkg::CW'((rad_w < span_w) ? rad_w : span_w);
            end
            lpf_pkg::E_PROBE:
            begin
            end
            lpf_pkg::E_CMP:
            begin
                if (chars_match)
                begin
                    k_next = lpf_pkg::CW'(k_w + 1'b1);
                end
            end
            lpf_pkg::E_FINISH:
            begin
                rad_we = 1'b1;
                if (reach_w > wr1_w)
                begin
                    wr1_next = lpf_pkg::CW'(reach_w);
                    wl_next  = lpf_pkg::AW'(cand_start);
                end
                // strictly longer only, earliest center keeps ties
                if (cand_len > (lpf_pkg::CW + 1)'(best_len_reg))
                begin
                    best_len_next   = lpf_pkg::CW'(cand_len);
                    best_start_next = lpf_pkg::AW'(cand_start);
                end
                if (last_center)
                begin
                    if (!pass_reg)
                    begin
                        pass_next = 1'b1;
                        i_next    = '0;
                        wl_next   = '0;
                        wr1_next  = '0;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
                else
                begin
                    i_next = lpf_pkg::AW'(i_w + 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lpf_pkg::E_IDLE;
            pass_reg       <= 1'b0;
            done_reg       <= 1'b0;
            i_reg          <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            wl_reg         <= '0;
            wr1_reg        <= '0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            done_reg       <= done_next;
            i_reg          <= i_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            wl_reg         <= wl_next;
            wr1_reg        <= wr1_next;
            best_len_reg   <= best_len_next;
            best_start_reg <= best_start_next;
        end
    end

    // result toward the top level
    assign res.done   = done_reg;
    assign res.start  = best_start_reg;
    assign res.length = best_len_reg;

endmodule

/* design/longest_palindrome_finder_core.sv */
// Longest palindromic substring finder. Characters arrive one per request and are
// stored at one per cycle; the request flagged last_char starts Manacher's search
// (odd centers, then even centers) and the block stalls its input until the result
// has moved into the output register. The search runs one character-pair compare
// at a time through the text store, whose reads are registered, so each compare
// takes a probe state and a compare state, and each center adds a setup state (and
// a mirror state inside the window) and a finish state. Bytes beyond 1024 are
// dropped and reported through too_long; the result gives the start and length,
// the earliest center winning ties and an odd palindrome beating an even one of
// the same length.
module longest_palindrome_finder_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lpf_pkg::BYTE_W-1:0] char_byte,
    input  logic                       last_char,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [lpf_pkg::AW-1:0]     pal_start,
    output logic [lpf_pkg::CW-1:0]     pal_length,
    output logic                       too_long
);

    lpf_pkg::lpf_top_state_t state_reg, state_next;

    logic [lpf_pkg::CW-1:0] count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic                   ovf_hold_reg, ovf_hold_next;
    logic                   out_valid_reg, out_valid_next;
    logic [lpf_pkg::AW-1:0] pal_start_reg;
    logic [lpf_pkg::CW-1:0] pal_length_reg;
    logic                   too_long_reg;

    logic                   in_acc;
    logic                   has_room;
    logic                   out_free;
    logic                   out_load;

    lpf_pkg::lpf_wr_t  txt_wr;
    lpf_pkg::lpf_cmd_t cmd;
    lpf_pkg::lpf_res_t res;

    assign in_acc   = in_valid && !in_stall;
    assign has_room = count_reg < lpf_pkg::CW'(lpf_pkg::MAX_LEN);
    assign out_free = !out_valid_reg || !out_stall;

    // load side write and search start
    assign txt_wr.en   = in_acc && has_room;
    assign txt_wr.addr = count_reg[lpf_pkg::AW-1:0];
    assign txt_wr.data = char_byte;
    assign cmd.start   = in_acc && last_char;
    assign cmd.n       = has_room ? lpf_pkg::CW'(count_reg + 1'b1) : count_reg;

    lpf_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .txt_wr (txt_wr),
        .cmd    (cmd),
        .res    (res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpf_pkg::T_LOAD:
            begin
                if (in_acc && last_char)
                begin
                    state_next = lpf_pkg::T_SEARCH;
                end
            end
            lpf_pkg::T_SEARCH:
            begin
                if (res.done)
                begin
                    state_next = lpf_pkg::T_HOLD;
                end
            end
            lpf_pkg::T_HOLD:
            begin
                if (out_free)
                begin
                    state_next = lpf_pkg::T_LOAD;
                end
            end
            default:
            begin
                state_next = lpf_pkg::T_LOAD;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall = state_reg != lpf_pkg::T_LOAD;
        out_load = (state_reg == lpf_pkg::T_HOLD) && out_free;
    end

    // byte count and overflow tracking
    always_comb
    begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        ovf_hold_next = ovf_hold_reg;
        if (in_acc)
        begin
            if (last_char)
            begin
                count_next    = '0;
                ovf_next      = 1'b0;
                ovf_hold_next = ovf_reg || !has_room;
            end
            else if (has_room)
            begin
                count_next = lpf_pkg::CW'(count_reg + 1'b1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // output slot valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpf_pkg::T_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            ovf_hold_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            ovf_hold_reg  <= ovf_hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pal_start_reg  <= res.start;
            pal_length_reg <= res.length;
            too_long_reg   <= ovf_hold_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pal_start  = pal_start_reg;
    assign pal_length = pal_length_reg;
    assign too_long   = too_long_reg;

endmodule

/* design/lpf_checker.sv */
// port-level checks of the palindrome finder, bound to the top level
`include "assert_macros.svh"

module lpf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic [lpf_pkg::BYTE_W-1:0] char_byte,
    input logic                       last_char,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [lpf_pkg::AW-1:0]     pal_start,
    input logic [lpf_pkg::CW-1:0]     pal_length,
    input logic                       too_long
);

    // a stalled result stays offered
    `LPF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // a stalled result keeps its fields
    `LPF_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(pal_start) && $stable(pal_length) && $stable(too_long),
        "result changed while stalled")

    // the last character starts a search, so input stalls next cycle
    `LPF_ASSERT_NEXT(a_search_stall, in_valid && !in_stall && last_char, in_stall,
        "input not stalled after last character")

    // every result names a non-empty palindrome
    `LPF_ASSERT_SAME(a_len_nonzero, out_valid, pal_length != '0, "empty palindrome reported")

    // the palindrome lies inside the store
    `LPF_ASSERT_SAME(a_in_range, out_valid,
        ((lpf_pkg::CW + 1)'(pal_start) + (lpf_pkg::CW + 1)'(pal_length))
            <= (lpf_pkg::CW + 1)'(lpf_pkg::MAX_LEN),
        "palindrome runs past capacity")

endmodule

bind longest_palindrome_finder_core lpf_checker u_lpf_checker (.*);

/* test/longest_palindrome_finder_core_tb.sv */
// self-checking testbench for the longest palindromic substring finder
`timescale 1ns / 100ps

module longest_palindrome_finder_core_tb;

    localparam int RANDOM_CHARS = 750;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int QUIET_FROM   = 3000;
    localparam int QUIET_TO     = 9000;
    localparam int SETTLE       = 64;

    // one palindrome report as it leaves the block
    typedef struct {
        logic [lpf_pkg::AW-1:0] start;
        logic [lpf_pkg::CW-1:0] length;
        logic                   too_long;
    } pal_report_t;

    // tracks the string being loaded, predicts each report and checks it
    class palindrome_tracker;
        logic [7:0]  text [lpf_pkg::MAX_LEN];
        int          odd_rad [lpf_pkg::MAX_LEN];
        int          even_rad [lpf_pkg::MAX_LEN];
        int          char_count;
        bit          dropped;
        pal_report_t pending_reports [$];
        int          mismatches;

        function new();
            char_count = 0;
            dropped    = 1'b0;
            mismatches = 0;
        endfunction

        // manacher over the stored bytes, odd centers then even centers
        function pal_report_t find_longest(int n);
            int          i, k, m, j, wl, wr, best_len, best_start;
            pal_report_t rep;
            best_len   = 0;
            best_start = 0;
            // odd centers: k counts the center itself
            wl = 0;
            wr = -1;
            for (i = 0; i < n; i++)
            begin
                if (i > wr)
                begin
                    k = 1;
                end
                else
                begin
                    j = wl + wr - i;
                    k = (j < 0 || j >= n) ? 0 : odd_rad[j];
                    m = wr - i + 1;
                    if (m < k)
                        k = m;
                end
                while (i - k >= 0 && i + k < n && text[i - k] == text[i + k])
                    k++;
                odd_rad[i] = k;
                if (i + k - 1 > wr)
                begin
                    wl = i - k + 1;
                    wr = i + k - 1;
                end
                if (2 * k - 1 > best_len)
                begin
                    best_len   = 2 * k - 1;
                    best_start = i - k + 1;
                end
            end
            // even centers: center sits between i-1 and i
            wl = 0;
            wr = -1;
            for (i = 0; i < n; i++)
            begin
                if (i > wr)
                begin
                    k = 0;
                end
                else
                begin
                    j = wl + wr - i + 1;
                    k = (j < 0 || j >= n) ? 0 : even_rad[j];
                    m = wr - i + 1;
                    if (m < k)
                        k = m;
                end
                while (i - k - 1 >= 0 && i + k < n && text[i - k - 1] == text[i + k])
                    k++;
                even_rad[i] = k;
                if (i + k - 1 > wr)
                begin
                    wl = i - k;
                    wr = i + k - 1;
                end
                if (2 * k > best_len)
                begin
                    best_len   = 2 * k;
                    best_start = i - k;
                end
            end
            rep.start    = best_start[lpf_pkg::AW-1:0];
            rep.length   = best_len[lpf_pkg::CW-1:0];
            rep.too_long = dropped;
            return rep;
        endfunction

        // accepted character request: store or drop, predict on the last one
        function void note_char(logic [7:0] b, logic last);
            if (char_count < lpf_pkg::MAX_LEN)
            begin
                text[char_count] = b;
                char_count++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (last)
            begin
                pending_reports.push_back(find_longest(char_count));
                char_count = 0;
                dropped    = 1'b0;
            end
        endfunction

        // compare one report against the oldest prediction
        function void check_report(logic [lpf_pkg::AW-1:0] start,
                                   logic [lpf_pkg::CW-1:0] length, logic too_long);
            pal_report_t exp_rep;
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected report start %0d length %0d too_long %0d",
                         $time, start, length, too_long);
                mismatches++;
                return;
            end
            exp_rep = pending_reports.pop_front();
            if (start !== exp_rep.start)
            begin
                $display("%0t: pal_start expected %0d actual %0d",
                         $time, exp_rep.start, start);
                mismatches++;
            end
            if (length !== exp_rep.length)
            begin
                $display("%0t: pal_length expected %0d actual %0d",
                         $time, exp_rep.length, length);
                mismatches++;
            end
            if (too_long !== exp_rep.too_long)
            begin
                $display("%0t: too_long expected %0d actual %0d",
                         $time, exp_rep.too_long, too_long);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_stall;
    logic [7:0]                 char_byte   = 8'h00;
    logic                       last_char   = 1'b0;
    logic                       out_valid;
    logic                       out_stall   = 1'b0;
    logic [lpf_pkg::AW-1:0]     pal_start;
    logic [lpf_pkg::CW-1:0]     pal_length;
    logic                       too_long;

    int                         cycle_count = 0;
    logic [7:0]                 text_buf [$];
    palindrome_tracker          tracker = new();

    longest_palindrome_finder_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_byte  (char_byte),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pal_start  (pal_start),
        .pal_length (pal_length),
        .too_long   (too_long)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // random idle decision, with one quiet stretch of no idling
    function automatic bit take_gap();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 8;
    endfunction

    // cycle counter and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stall, check accepted reports
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.check_report(pal_start, pal_length, too_long);
            out_stall <= take_gap();
        end
    end

    // send one character request and wait for acceptance
    task automatic send_char(input logic [7:0] b, input logic last);
        while (take_gap())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= b;
        last_char <= last;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_char(b, last);
    endtask

    // send the whole text buffer, last mark on its final byte
    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    // stimulus
    initial
    begin
        int         len, mode, asize, plen, pos, j, random_chars;
        logic [7:0] alpha [4];

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single byte, smallest string
        text_buf = '{8'h00};
        send_text();
        // two equal bytes at the top value: even palindrome
        text_buf = '{8'hff, 8'hff};
        send_text();
        // odd palindrome
        text_buf = '{8'h61, 8'h62, 8'h61};
        send_text();
        // even palindrome of length four
        text_buf = '{8'h61, 8'h62, 8'h62, 8'h61};
        send_text();
        // all distinct: earliest single byte wins
        text_buf = '{8'h01, 8'h80, 8'h7f, 8'hfe};
        send_text();
        // two equal-length palindromes: earliest wins
        text_buf = '{8'h61, 8'h62, 8'h61, 8'h63, 8'h64, 8'h63};
        send_text();

        // random strings, mostly short, small alphabets, planted palindromes
        random_chars = 0;
        while (random_chars < RANDOM_CHARS)
        begin
            text_buf.delete();
            len   = $urandom_range(1, 24);
            mode  = $urandom_range(0, 9);
            asize = $urandom_range(1, 4);
            for (j = 0; j < 4; j++)
                alpha[j] = 8'($urandom_range(0, 255));
            for (j = 0; j < len; j++)
            begin
                if (mode < 2)
                    text_buf.push_back(8'($urandom_range(0, 255)));
                else
                    text_buf.push_back(alpha[$urandom_range(0, asize - 1)]);
            end
            if (mode >= 6)
            begin
                plen = $urandom_range(1, len);
                pos  = $urandom_range(0, len - plen);
                for (j = 0; j < plen / 2; j++)
                    text_buf[pos + plen - 1 - j] = text_buf[pos + j];
            end
            send_text();
            random_chars += len;
        end
        in_valid  <= 1'b0;
        last_char <= 1'b0;

        // drain and settle
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* longest_palindrome_finder_core.f */
+incdir+design
design/lpf_pkg.sv
design/lpf_engine.sv
design/longest_palindrome_finder_core.sv
design/lpf_checker.sv
test/longest_palindrome_finder_core_tb.sv
